FILE: sv/u8pl_pkg.sv
`timescale 1ns / 1ps

package u8pl_pkg;

    // byte classes
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // replacement character '?'
    localparam logic [15:0] REPL_CP   = 16'h003F;
    localparam logic [6:0]  REPL_BASE = 7'h3F;

    // pending byte count
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // result queue sizing: up to three results per byte plus one still waiting
    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_ACUTE  = 3'd1,
        ACC_DOT    = 3'd2,
        ACC_OGONEK = 3'd3,
        ACC_STROKE = 3'd4
    } accent_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic [6:0]  base_letter;
        accent_t     accent_kind;
        logic        last_of_run;
    } res_entry_t;

    typedef struct packed {
        logic [1:0]                 num;
        res_entry_t [MAX_RES-1:0]   slot;
    } res_bundle_t;

    // code point to drawn letter plus diacritic
    function automatic res_entry_t make_entry(logic [15:0] cp, logic last);
        res_entry_t e;
        e.code_point  = cp;
        e.base_letter = (cp < 16'h0080) ? cp[6:0] : REPL_BASE;
        e.accent_kind = ACC_NONE;
        e.last_of_run = last;
        case (cp)
            16'h0104: begin e.base_letter = 7'h41; e.accent_kind = ACC_OGONEK; end
            16'h0105: begin e.base_letter = 7'h61; e.accent_kind = ACC_OGONEK; end
            16'h0106: begin e.base_letter = 7'h43; e.accent_kind = ACC_ACUTE;  end
            16'h0107: begin e.base_letter = 7'h63; e.accent_kind = ACC_ACUTE;  end
            16'h0118: begin e.base_letter = 7'h45; e.accent_kind = ACC_OGONEK; end
            16'h0119: begin e.base_letter = 7'h65; e.accent_kind = ACC_OGONEK; end
            16'h0141: begin e.base_letter = 7'h4C; e.accent_kind = ACC_STROKE; end
            16'h0142: begin e.base_letter = 7'h6C; e.accent_kind = ACC_STROKE; end
            16'h0143: begin e.base_letter = 7'h4E; e.accent_kind = ACC_ACUTE;  end
            16'h0144: begin e.base_letter = 7'h6E; e.accent_kind = ACC_ACUTE;  end
            16'h00D3: begin e.base_letter = 7'h4F; e.accent_kind = ACC_ACUTE;  end
            16'h00F3: begin e.base_letter = 7'h6F; e.accent_kind = ACC_ACUTE;  end
            16'h015A: begin e.base_letter = 7'h53; e.accent_kind = ACC_ACUTE;  end
            16'h015B: begin e.base_letter = 7'h73; e.accent_kind = ACC_ACUTE;  end
            16'h0179: begin e.base_letter = 7'h5A; e.accent_kind = ACC_ACUTE;  end
            16'h017A: begin e.base_letter = 7'h7A; e.accent_kind = ACC_ACUTE;  end
            16'h017B: begin e.base_letter = 7'h5A; e.accent_kind = ACC_DOT;    end
            16'h017C: begin e.base_letter = 7'h7A; e.accent_kind = ACC_DOT;    end
            default: ;
        endcase
        return e;
    endfunction

endpackage

FILE: sv/utf8_decode_polish_transliterate_unit.sv
`timescale 1ns / 1ps

// channel   | ports                    | payload
// ----------+--------------------------+-----------------------------------------------
// byte in   | s_axis_t{valid,ready}    | tdata[7:0] text_byte
// char out  | m_axis_t{valid,ready}    | tdata code_point, base_letter, accent_kind;
//           |                          | tlast last_of_run
//
// each input transaction is decoded in the cycle it is taken; its 0..3 results land in a
// four-entry result queue and leave one per cycle while m_axis_tready is high, the first
// result entering the queue on the cycle after the input transaction.
// input is taken while the queue holds at most one result, so a stream of one result
// per byte runs at one byte per cycle while m_axis_tready is high; a byte giving two or
// three results takes more output bandwidth and briefly holds off s_axis_tready.
// rst_n clears the pending lead bytes and empties the queue.
// a stall on m_axis_tready holds the current result and fills the queue.

module utf8_decode_polish_transliterate_unit
    import u8pl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] code_point, [22:16] base_letter,
                                        // [25:23] accent_kind, [31:26] zero
    output logic        m_axis_tlast    // last_of_run
);

    res_bundle_t res;
    logic        accept;
    logic        pop;

    // result queue, payload only
    res_entry_t        q_reg [QDEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QCNT_W-1:0] push_cnt;
    res_entry_t        head;

    // room for a full three-result transaction even with one result still waiting
    assign s_axis_tready = cnt_reg <= QCNT_W'(QDEPTH - MAX_RES);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = cnt_reg != '0;
    assign pop           = m_axis_tvalid && m_axis_tready;

    u8pl_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (s_axis_tdata),
        .res       (res)
    );

    assign push_cnt    = accept ? QCNT_W'(res.num) : '0;
    assign cnt_next    = cnt_reg + push_cnt - QCNT_W'(pop);
    assign wr_ptr_next = wr_ptr_reg + push_cnt[QPTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // results of one transaction go to consecutive entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (accept && (2'(i) < res.num))
            begin
                q_reg[wr_ptr_reg + QPTR_W'(i)] <= res.slot[i];
            end
        end
    end

    assign head         = q_reg[rd_ptr_reg];
    assign m_axis_tdata = {6'd0, head.accent_kind, head.base_letter, head.code_point};
    assign m_axis_tlast = head.last_of_run;

endmodule

FILE: sv/u8pl_decode.sv
`timescale 1ns / 1ps

module u8pl_decode
    import u8pl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  text_byte,
    output res_bundle_t res
);

    logic [7:0] held_lead_reg, held_lead_next;
    logic [7:0] held_second_reg, held_second_next;
    logic [1:0] held_count_reg, held_count_next;

    logic        b_cont;
    logic        lead_is2;
    logic        b_lead;
    logic        fresh_v;
    logic        fresh_hold;
    logic [15:0] fresh_cp;
    logic [1:0]  rep;
    logic        tail_v;
    logic [15:0] tail_cp;
    logic [1:0]  num;

    assign b_cont   = (text_byte & CONT_MASK) == CONT_TAG;
    assign lead_is2 = (held_lead_reg >= LEAD2_LO) && (held_lead_reg <= LEAD2_HI);
    assign b_lead   = (text_byte >= LEAD2_LO) && (text_byte <= LEAD3_HI);

    // byte taken as a new lead with nothing pending
    always_comb
    begin
        fresh_v    = 1'b0;
        fresh_hold = 1'b0;
        fresh_cp   = REPL_CP;
        if (!text_byte[7])
        begin
            fresh_v  = 1'b1;
            fresh_cp = {8'h00, text_byte};
        end
        else if (b_lead)
        begin
            fresh_hold = 1'b1;
        end
        else
        begin
            fresh_v = 1'b1;
        end
    end

    always_comb
    begin
        rep              = 2'd0;
        tail_v           = 1'b0;
        tail_cp          = REPL_CP;
        held_lead_next   = held_lead_reg;
        held_second_next = held_second_reg;
        held_count_next  = HELD_NONE;
        if (text_byte == 8'h00)
        begin
            // flush: one replacement per pending byte
            rep              = (held_count_reg == HELD_NONE) ? 2'd0 :
                               (held_count_reg == HELD_ONE)  ? 2'd1 : 2'd2;
            held_lead_next   = 8'h00;
            held_second_next = 8'h00;
        end
        else
        begin
            case (held_count_reg)
                HELD_ONE:
                begin
                    if (b_cont && lead_is2)
                    begin
                        tail_v  = 1'b1;
                        tail_cp = {5'd0, held_lead_reg[4:0], text_byte[5:0]};
                    end
                    else if (b_cont)
                    begin
                        held_second_next = text_byte;
                        held_count_next  = HELD_TWO;
                    end
                    else
                    begin
                        rep     = 2'd1;
                        tail_v  = fresh_v;
                        tail_cp = fresh_cp;
                        if (fresh_hold)
                        begin
                            held_lead_next  = text_byte;
                            held_count_next = HELD_ONE;
                        end
                    end
                end
                HELD_TWO:
                begin
                    if (b_cont)
                    begin
                        tail_v  = 1'b1;
                        tail_cp = {held_lead_reg[3:0], held_second_reg[5:0],
                                   text_byte[5:0]};
                    end
                    else
                    begin
                        rep     = 2'd2;
                        tail_v  = fresh_v;
                        tail_cp = fresh_cp;
                        if (fresh_hold)
                        begin
                            held_lead_next  = text_byte;
                            held_count_next = HELD_ONE;
                        end
                    end
                end
                default:
                begin
                    tail_v  = fresh_v;
                    tail_cp = fresh_cp;
                    if (fresh_hold)
                    begin
                        held_lead_next  = text_byte;
                        held_count_next = HELD_ONE;
                    end
                end
            endcase
        end
    end

    // replacements first, then the tail character
    assign num = rep + {1'b0, tail_v};

    always_comb
    begin
        res.num = num;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res.slot[i] = make_entry((2'(i) < rep) ? REPL_CP : tail_cp,
                                     2'(i) == (num - 2'd1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg   <= 8'h00;
            held_second_reg <= 8'h00;
            held_count_reg  <= HELD_NONE;
        end
        else if (accept)
        begin
            held_lead_reg   <= held_lead_next;
            held_second_reg <= held_second_next;
            held_count_reg  <= held_count_next;
        end
    end

endmodule

FILE: sv/u8pl_checker.sv
`timescale 1ns / 1ps

module u8pl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // plain ascii draws as itself
    a_ascii_self: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[15:7] == 9'd0) |->
            (m_axis_tdata[22:16] == m_axis_tdata[6:0]) && (m_axis_tdata[25:23] == 3'd0))
        else $error("ascii character not passed through");

    // diacritics only on the polish letters, all below 0x200
    a_accent_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[25:23] != 3'd0) |->
            (m_axis_tdata[15:9] == 7'd0) && (m_axis_tdata[25:23] <= 3'd4)
            && (m_axis_tdata[31:26] == 6'd0))
        else $error("bad accent on output");

    // unmapped characters above ascii draw as '?'
    a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[15:7] != 9'd0) && (m_axis_tdata[25:23] == 3'd0) |->
            m_axis_tdata[22:16] == 7'h3F)
        else $error("unmapped character not replaced");

endmodule

bind utf8_decode_polish_transliterate_unit u8pl_checker u_u8pl_checker (.*);
